>>> sv/bnc_pkg.sv
// shared types and codes for the bracket nesting checker
package bnc_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned STATUS_W = 3;

  // open or close event
  typedef enum logic {
    CMD_OPEN  = 1'b0,
    CMD_CLOSE = 1'b1
  } cmd_t;

  // bracket kinds, code three folds onto brace
  localparam logic [KIND_W-1:0] KIND_PAREN  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SQUARE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_BRACE  = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_HALTED   = 3'd4
  } status_t;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic fetch;
    logic load;
    logic emit;
  } ctl_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic need_reload;
    logic out_busy;
  } dp_stat_t;

  function automatic logic [KIND_W-1:0] fold_kind(input logic [KIND_W-1:0] k);
    logic [KIND_W-1:0] r;
    case (k)
      KIND_PAREN:  r = KIND_PAREN;
      KIND_SQUARE: r = KIND_SQUARE;
      default:     r = KIND_BRACE;
    endcase
    return r;
  endfunction

endpackage

>>> sv/bnc_ctrl.sv
// sequencing state machine of the bracket nesting checker
module bnc_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  bnc_pkg::dp_stat_t  stat,
  output bnc_pkg::ctl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_LOAD  = 4'b0100,
    S_EMIT  = 4'b1000
  } state_t;

  state_t state_r;
  state_t state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = stat.need_reload ? S_FETCH : S_EMIT;
        end
      end
      S_FETCH: begin
        cmd.fetch = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.load  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (!stat.out_busy) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> sv/bnc_dp.sv
// stack memory, top-of-stack cache, status and result register
module bnc_dp #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned COLUMN_BITS = 10,
  localparam int unsigned AW = $clog2(STACK_DEPTH),
  localparam int unsigned DW = $clog2(STACK_DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  bnc_pkg::ctl_cmd_t            cmd,
  output bnc_pkg::dp_stat_t            stat,
  input  logic                         in_cmd,
  input  logic [bnc_pkg::KIND_W-1:0]   in_bracket_kind,
  input  logic [LINE_BITS-1:0]         in_line_number,
  input  logic [COLUMN_BITS-1:0]       in_column,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [bnc_pkg::STATUS_W-1:0] out_status,
  output logic [bnc_pkg::KIND_W-1:0]   out_open_kind,
  output logic [LINE_BITS-1:0]         out_open_line,
  output logic [COLUMN_BITS-1:0]       out_open_column,
  output logic [DW-1:0]                out_depth,
  output logic                         out_empty_res
);

  localparam int unsigned EW = bnc_pkg::KIND_W + LINE_BITS + COLUMN_BITS;
  localparam logic [DW-1:0] FULL_CNT = DW'(STACK_DEPTH);
  localparam logic [DW-1:0] ONE_CNT  = DW'(1);

  logic [EW-1:0] mem [STACK_DEPTH];
  logic [EW-1:0] rd_data_r;
  logic [EW-1:0] top_r;
  logic [DW-1:0] sp_r;
  logic [DW-1:0] sp_nxt;
  logic          halted_r;
  logic          halted_nxt;
  bnc_pkg::status_t status_r;
  bnc_pkg::status_t status_nxt;

  logic [bnc_pkg::KIND_W-1:0] kind_f;
  logic [EW-1:0]              new_entry;
  logic                       do_push;
  logic                       do_pop;
  logic                       sp_empty;
  logic [DW-1:0]              sp_m1;

  logic                             out_valid_r;
  logic [bnc_pkg::STATUS_W-1:0]     out_status_r;
  logic [EW-1:0]                    out_entry_r;
  logic [DW-1:0]                    out_depth_r;
  logic                             out_empty_r;

  assign kind_f    = bnc_pkg::fold_kind(in_bracket_kind);
  assign new_entry = {kind_f, in_line_number, in_column};
  assign sp_empty  = (sp_r == '0);
  assign sp_m1     = sp_r - ONE_CNT;

  // decide the step from the cached top entry
  always_comb begin
    status_nxt = bnc_pkg::ST_OK;
    halted_nxt = halted_r;
    sp_nxt     = sp_r;
    do_push    = 1'b0;
    do_pop     = 1'b0;
    if (halted_r) begin
      status_nxt = bnc_pkg::ST_HALTED;
    end else if (in_cmd == bnc_pkg::CMD_OPEN) begin
      if (sp_r == FULL_CNT) begin
        status_nxt = bnc_pkg::ST_OVERFLOW;
        halted_nxt = 1'b1;
      end else begin
        do_push = 1'b1;
        sp_nxt  = sp_r + ONE_CNT;
      end
    end else begin
      if (sp_empty) begin
        status_nxt = bnc_pkg::ST_EMPTY;
        halted_nxt = 1'b1;
      end else if (top_r[EW-1 -: bnc_pkg::KIND_W] != kind_f) begin
        status_nxt = bnc_pkg::ST_MISMATCH;
        halted_nxt = 1'b1;
      end else begin
        do_pop = 1'b1;
        sp_nxt = sp_m1;
      end
    end
  end

  // a pop that leaves entries behind must refetch the new top
  assign stat.need_reload = do_pop && (sp_r != ONE_CNT);
  assign stat.out_busy    = out_valid_r && out_stall;

  always_ff @(posedge clk) begin
    if (cmd.accept && do_push) begin
      mem[sp_r[AW-1:0]] <= new_entry;
    end
    if (cmd.fetch) begin
      rd_data_r <= mem[sp_m1[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sp_r     <= '0;
      halted_r <= 1'b0;
    end else if (cmd.accept) begin
      sp_r     <= sp_nxt;
      halted_r <= halted_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      status_r <= status_nxt;
      if (do_push) begin
        top_r <= new_entry;
      end
    end else if (cmd.load) begin
      top_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_status_r <= status_r;
      out_entry_r  <= sp_empty ? '0 : top_r;
      out_depth_r  <= sp_r;
      out_empty_r  <= sp_empty;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_open_kind   = out_entry_r[EW-1 -: bnc_pkg::KIND_W];
  assign out_open_line   = out_entry_r[COLUMN_BITS +: LINE_BITS];
  assign out_open_column = out_entry_r[COLUMN_BITS-1:0];
  assign out_depth       = out_depth_r;
  assign out_empty_res   = out_empty_r;

  a_sp_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sp_r <= FULL_CNT)
    else $error("stack pointer beyond depth");

  a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    halted_r |=> halted_r)
    else $error("halt flag cleared without reset");

  a_halted_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_status_r == bnc_pkg::ST_HALTED)) |-> halted_r)
    else $error("halted result while not halted");

  a_empty_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_empty_r == (out_depth_r == '0)))
    else $error("empty flag disagrees with depth");

endmodule

>>> sv/bracket_nesting_checker.sv
// top level of the bracket nesting checker: controller and datapath
//
// usage
//   input channel: one bracket event per beat (in_cmd open or close, in_bracket_kind,
//   in_line_number, in_column), taken at a clock edge with in_valid high and
//   in_stall low
//   result channel: exactly one result beat per input beat, in order, with status,
//   the top open entry (or the expected one on a mismatch), depth and empty flag
//   result path: push, failed or halted beats and a pop that empties the stack go from
//   the accepting edge through the emit state to out_valid; a pop that leaves entries
//   first passes the fetch and load states, since the new top comes out of the stack
//   memory through its registered read port
//   the controller works on one beat at a time and takes the next beat only once the
//   result of the last one has gone into the output register
//   reset: rst_n low at a clock edge empties the stack, clears the halt flag and
//   drops out_valid; the stack memory itself is not cleared
//   stall: a result waits in the output register while out_stall is high and the
//   next beat is still taken and worked on; it then waits for the register to free
//   after any error the block answers halted until the next reset
module bracket_nesting_checker #(
  parameter int unsigned STACK_DEPTH = 64,
  parameter int unsigned LINE_BITS   = 16,
  parameter int unsigned COLUMN_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_cmd,
  input  logic [bnc_pkg::KIND_W-1:0]           in_bracket_kind,
  input  logic [LINE_BITS-1:0]                 in_line_number,
  input  logic [COLUMN_BITS-1:0]               in_column,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [bnc_pkg::STATUS_W-1:0]         out_status,
  output logic [bnc_pkg::KIND_W-1:0]           out_open_kind,
  output logic [LINE_BITS-1:0]                 out_open_line,
  output logic [COLUMN_BITS-1:0]               out_open_column,
  output logic [$clog2(STACK_DEPTH + 1)-1:0]   out_depth,
  output logic                                 out_empty_res
);

  // command and status bundles between the two halves
  bnc_pkg::ctl_cmd_t ctl_cmd;
  bnc_pkg::dp_stat_t dp_stat;

  // sequencer: accept, optional top refetch, result hand-off
  bnc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  // stack memory, cached top entry and output register
  bnc_dp #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctl_cmd),
    .stat            (dp_stat),
    .in_cmd          (in_cmd),
    .in_bracket_kind (in_bracket_kind),
    .in_line_number  (in_line_number),
    .in_column       (in_column),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_open_kind   (out_open_kind),
    .out_open_line   (out_open_line),
    .out_open_column (out_open_column),
    .out_depth       (out_depth),
    .out_empty_res   (out_empty_res)
  );

endmodule

>>> verif/bnc_tb_pkg.sv
// stack predictor and result scoreboard for the bracket nesting checker bench
package bnc_tb_pkg;
  import bnc_pkg::*;

  localparam int unsigned STACK_DEPTH = 64;
  localparam int unsigned LINE_BITS   = 16;
  localparam int unsigned COLUMN_BITS = 10;
  localparam int unsigned DEPTH_W     = $clog2(STACK_DEPTH + 1);

  // unused kind code, the block treats it as a brace
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]      kind;
    logic [LINE_BITS-1:0]   line_no;
    logic [COLUMN_BITS-1:0] col_no;
  } open_entry_t;

  typedef struct {
    status_t                status;
    logic [KIND_W-1:0]      kind;
    logic [LINE_BITS-1:0]   line_no;
    logic [COLUMN_BITS-1:0] col_no;
    logic [DEPTH_W-1:0]     depth;
    logic                   empty;
  } nesting_result_t;

  class bracket_scoreboard;
    open_entry_t     open_stack[STACK_DEPTH];
    int unsigned     held_count;
    bit              halted;
    nesting_result_t awaited_results[$];
    int unsigned     errors;
    int unsigned     beats;
    int unsigned     results;
    int unsigned     deepest;

    function new();
      held_count = 0;
      halted     = 1'b0;
      errors     = 0;
      beats      = 0;
      results    = 0;
      deepest    = 0;
    endfunction

    function int unsigned held();
      return held_count;
    endfunction

    function logic [KIND_W-1:0] top_kind();
      return (held_count > 0) ? open_stack[held_count-1].kind : KIND_PAREN;
    endfunction

    function int unsigned outstanding();
      return awaited_results.size();
    endfunction

    // update the stack with one accepted beat and queue the result it must give
    function void note_bracket(cmd_t cmd, logic [KIND_W-1:0] kind_in,
                               logic [LINE_BITS-1:0] line_no,
                               logic [COLUMN_BITS-1:0] col_no);
      logic [KIND_W-1:0] kind;
      nesting_result_t   res;
      kind       = (kind_in == KIND_SPARE) ? KIND_BRACE : kind_in;
      res.status = ST_OK;
      if (halted) begin
        res.status = ST_HALTED;
      end else if (cmd == CMD_OPEN) begin
        if (held_count >= STACK_DEPTH) begin
          res.status = ST_OVERFLOW;
          halted     = 1'b1;
        end else begin
          open_stack[held_count] = '{kind, line_no, col_no};
          held_count++;
        end
      end else if (held_count == 0) begin
        res.status = ST_EMPTY;
        halted     = 1'b1;
      end else if (open_stack[held_count-1].kind != kind) begin
        res.status = ST_MISMATCH;
        halted     = 1'b1;
      end else begin
        held_count--;
      end
      if (held_count > 0) begin
        res.kind    = open_stack[held_count-1].kind;
        res.line_no = open_stack[held_count-1].line_no;
        res.col_no  = open_stack[held_count-1].col_no;
      end else begin
        res.kind    = '0;
        res.line_no = '0;
        res.col_no  = '0;
      end
      res.depth = DEPTH_W'(held_count);
      res.empty = (held_count == 0);
      awaited_results.push_back(res);
      beats++;
      if (held_count > deepest) deepest = held_count;
    endfunction

    function void compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(logic [STATUS_W-1:0] status, logic [KIND_W-1:0] kind,
                               logic [LINE_BITS-1:0] line_no,
                               logic [COLUMN_BITS-1:0] col_no,
                               logic [DEPTH_W-1:0] depth, logic empty);
      nesting_result_t want;
      if (awaited_results.size() == 0) begin
        $error("result beat with nothing awaited: status %0h depth %0d", status, depth);
        errors++;
        return;
      end
      want = awaited_results.pop_front();
      results++;
      compare_field("status", 32'(want.status), 32'(status));
      compare_field("open_kind", 32'(want.kind), 32'(kind));
      compare_field("open_line", 32'(want.line_no), 32'(line_no));
      compare_field("open_column", 32'(want.col_no), 32'(col_no));
      compare_field("depth", 32'(want.depth), 32'(depth));
      compare_field("empty_res", 32'(want.empty), 32'(empty));
    endfunction
  endclass

endpackage

>>> verif/bracket_nesting_checker_tb.sv
// testbench top: drives bracket beats into the nesting checker and checks every result
module bracket_nesting_checker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bnc_pkg::*;
  import bnc_tb_pkg::*;

  // cycles with no beat on either channel before the run is declared hung;
  // the longest legal quiet stretch is the deliberate receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD      = 300;
  localparam int unsigned HOLD_AT        = 150;
  localparam int unsigned TAIL_CYCLES    = 20;
  localparam int unsigned RANDOM_BEATS   = 1000;
  localparam int unsigned HALTED_BEATS   = 20;

  // which error ends the run; only one can happen since the halt is sticky
  typedef enum {FINALE_UNDERFLOW, FINALE_MISMATCH, FINALE_OVERFLOW} finale_t;

  logic                   clk = 1'b0;
  logic                   rst_n;
  logic                   in_valid;
  logic                   in_stall;
  logic                   in_cmd;
  logic [KIND_W-1:0]      in_bracket_kind;
  logic [LINE_BITS-1:0]   in_line_number;
  logic [COLUMN_BITS-1:0] in_column;
  logic                   out_valid;
  logic                   out_stall;
  logic [STATUS_W-1:0]    out_status;
  logic [KIND_W-1:0]      out_open_kind;
  logic [LINE_BITS-1:0]   out_open_line;
  logic [COLUMN_BITS-1:0] out_open_column;
  logic [DEPTH_W-1:0]     out_depth;
  logic                   out_empty_res;

  bracket_scoreboard sb = new();
  bit                send_eager;
  bit                recv_eager;
  int unsigned       quiet_cycles;
  finale_t           finale;

  bracket_nesting_checker #(
    .STACK_DEPTH (STACK_DEPTH),
    .LINE_BITS   (LINE_BITS),
    .COLUMN_BITS (COLUMN_BITS)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_bracket_kind (in_bracket_kind),
    .in_line_number  (in_line_number),
    .in_column       (in_column),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_status      (out_status),
    .out_open_kind   (out_open_kind),
    .out_open_line   (out_open_line),
    .out_open_column (out_open_column),
    .out_depth       (out_depth),
    .out_empty_res   (out_empty_res)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // offer one beat, after a random gap unless in an eager stretch; returns at the
  // accepting edge with in_valid still high so a back-to-back beat needs no dip
  task automatic send_beat(cmd_t cmd, logic [KIND_W-1:0] kind,
                           logic [LINE_BITS-1:0] line_no, logic [COLUMN_BITS-1:0] col_no);
    int unsigned gap;
    gap = send_eager ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_cmd          <= cmd;
    in_bracket_kind <= kind;
    in_line_number  <= line_no;
    in_column       <= col_no;
    // in_stall is read before this edge's updates land, as the block sees it
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.note_bracket(cmd, kind, line_no, col_no);
  endtask

  task automatic open_random();
    send_beat(CMD_OPEN, KIND_W'($urandom_range(0, 3)),
              LINE_BITS'($urandom_range(0, 65535)), COLUMN_BITS'($urandom_range(0, 1023)));
  endtask

  // close whatever is on top; a brace is closed by the spare code half the time
  task automatic close_top();
    logic [KIND_W-1:0] kind;
    kind = sb.top_kind();
    if (kind == KIND_BRACE && $urandom_range(0, 1) == 1) kind = KIND_SPARE;
    send_beat(CMD_CLOSE, kind,
              LINE_BITS'($urandom_range(0, 65535)), COLUMN_BITS'($urandom_range(0, 1023)));
  endtask

  // sender stands back until every result has been seen
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  // one well-formed stretch of text: nest up to the target, then unwind to zero
  task automatic nest_and_unwind(int unsigned target);
    send_eager = ($urandom_range(0, 3) == 0);
    while (sb.held() < target) begin
      if (sb.held() > 0 && $urandom_range(0, 2) == 0) close_top();
      else open_random();
    end
    while (sb.held() > 0) begin
      if (sb.held() < target && $urandom_range(0, 2) == 0) open_random();
      else close_top();
    end
  endtask

  task automatic break_nesting();
    logic [KIND_W-1:0] wrong;
    case (finale)
      FINALE_UNDERFLOW: begin
        while (sb.held() > 0) close_top();
        send_beat(CMD_CLOSE, KIND_W'($urandom_range(0, 3)),
                  LINE_BITS'($urandom_range(0, 65535)), COLUMN_BITS'($urandom_range(0, 1023)));
      end
      FINALE_MISMATCH: begin
        if (sb.held() == 0) open_random();
        // any code that does not fold onto the kind on top
        do wrong = KIND_W'($urandom_range(0, 3));
        while (((wrong == KIND_SPARE) ? KIND_BRACE : wrong) == sb.top_kind());
        send_beat(CMD_CLOSE, wrong,
                  LINE_BITS'($urandom_range(0, 65535)), COLUMN_BITS'($urandom_range(0, 1023)));
      end
      default: begin
        while (sb.held() < STACK_DEPTH) open_random();
        open_random();
      end
    endcase
  endtask

  // stimulus
  initial begin
    int unsigned target;
    in_valid        <= 1'b0;
    in_cmd          <= CMD_OPEN;
    in_bracket_kind <= KIND_PAREN;
    in_line_number  <= '0;
    in_column       <= '0;
    rst_n           <= 1'b0;
    send_eager = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // directed: field extremes, every kind, the spare kind code on open and close
    send_beat(CMD_OPEN, KIND_PAREN, 16'h0000, 10'h000);
    send_beat(CMD_OPEN, KIND_SQUARE, 16'hffff, 10'h3ff);
    send_beat(CMD_OPEN, KIND_BRACE, 16'haaaa, 10'h155);
    send_beat(CMD_OPEN, KIND_SPARE, 16'h5555, 10'h2aa);
    send_beat(CMD_CLOSE, KIND_SPARE, 16'hffff, 10'h3ff);
    send_beat(CMD_CLOSE, KIND_BRACE, 16'h0000, 10'h000);
    send_beat(CMD_CLOSE, KIND_SQUARE, 16'h0001, 10'h001);
    send_beat(CMD_CLOSE, KIND_PAREN, 16'h8000, 10'h200);
    send_beat(CMD_OPEN, KIND_SPARE, 16'h0000, 10'h3ff);
    send_beat(CMD_CLOSE, KIND_BRACE, 16'hffff, 10'h000);
    send_beat(CMD_OPEN, KIND_BRACE, 16'h1234, 10'h0ff);
    send_beat(CMD_CLOSE, KIND_SPARE, 16'hfedc, 10'h300);
    send_eager = 1'b1;
    send_beat(CMD_OPEN, KIND_SQUARE, 16'h7fff, 10'h1ff);
    send_beat(CMD_OPEN, KIND_PAREN, 16'h00ff, 10'h3fe);
    send_beat(CMD_CLOSE, KIND_PAREN, 16'hff00, 10'h001);
    send_beat(CMD_CLOSE, KIND_SQUARE, 16'h0000, 10'h000);

    // hold the sender until the block has answered everything
    wait_drained();

    // random text: the first stretch nests right up to a full stack
    nest_and_unwind(STACK_DEPTH);
    while (sb.beats < RANDOM_BEATS) begin
      target = ($urandom_range(0, 7) == 0) ? STACK_DEPTH : $urandom_range(1, 12);
      nest_and_unwind(target);
    end

    // finish the text with one error, then check the block stays halted
    finale = finale_t'($urandom_range(0, 2));
    send_eager = 1'b0;
    break_nesting();
    repeat (HALTED_BEATS) begin
      send_beat(cmd_t'($urandom_range(0, 1)), KIND_W'($urandom_range(0, 3)),
                LINE_BITS'($urandom_range(0, 65535)), COLUMN_BITS'($urandom_range(0, 1023)));
    end

    wait_drained();
    // keep running for TAIL_CYCLES so a stray extra result would still be caught
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("checked %0d results from %0d bracket beats, deepest nesting %0d",
             sb.results, sb.beats, sb.deepest);
    $display("text ended with %s, then %0d beats while halted", finale.name(), HALTED_BEATS);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // result receiver: random hold-off before each result, eager stretches now and
  // then, and one long hold-off so the block backs up into its input
  initial begin
    int unsigned hold;
    int unsigned taken;
    taken = 0;
    recv_eager = 1'b0;
    out_stall <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (taken % 64 == 0) recv_eager = ($urandom_range(0, 3) == 0);
      if (taken == HOLD_AT) hold = LONG_HOLD;
      else hold = recv_eager ? 0 : $urandom_range(0, 19);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      do @(posedge clk); while (out_valid !== 1'b1);
      taken++;
    end
  end

  // result monitor
  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
      sb.check_result(out_status, out_open_kind, out_open_line, out_open_column,
                      out_depth, out_empty_res);
    end
  end

  // watchdog on cycles without any beat
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles, %0d results outstanding",
               quiet_cycles, sb.outstanding());
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
